@@ src/wpd_pkg.sv @@
`default_nettype none
package wpd_pkg;

	localparam int MAX_FILL_DEF   = 62;
	localparam int INDEX_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int RES_W          = 17;
	localparam logic [RES_W-1:0] RES_RESET = 17'd655;

	typedef struct packed {
		logic signed [31:0] way_x;
		logic signed [31:0] way_y;
		logic               final_point;
	} wpd_in_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               is_original;
		logic [23:0]        point_number;
		logic               fill_truncated;
		logic               run_last;
	} wpd_out_t;

	// Request and answer between the sequencer and the serial divider.
	typedef struct packed {
		logic        start;
		logic [82:0] num;
		logic [33:0] den;
	} wpd_div_req_t;

	typedef struct packed {
		logic        done;
		logic [82:0] quo;
	} wpd_div_rsp_t;

endpackage
`default_nettype wire

@@ src/wpd_div.sv @@
`default_nettype none
// Restoring divider that retires one quotient bit a cycle.
module wpd_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wpd_pkg::wpd_div_req_t  req,
	output wpd_pkg::wpd_div_rsp_t  rsp
);
	logic [82:0] num_q;
	logic [33:0] den_q;
	logic [33:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] shifted;
	logic [35:0] diff;

	// One trial subtraction on the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, num_q[82]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd83;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[35]) begin
				rem_q <= diff[33:0];
				num_q <= {num_q[81:0], 1'b1};
			end else begin
				rem_q <= shifted[33:0];
				num_q <= {num_q[81:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
endmodule
`default_nettype wire

@@ src/waypoint_path_densifier.sv @@
`default_nettype none
// Channel | direction | payload            | handshake
// in      | input     | wpd_pkg::wpd_in_t  | in_valid / in_stall
// out     | output    | wpd_pkg::wpd_out_t | out_valid / out_stall
// cfg     | input     | step_resolution    | cfg_we
// A segment takes a state of squares, one of sum, then the square root (one
// result bit a cycle from a shift register of operand pairs), then three
// serial divisions (point count and the x and y steps, each a start state and
// a wait state) in the one shared divider, then one emitted point per cycle
// while the output is not stalled, and one closing state per waypoint.
// Squares come from a 32x32 multiply each, registered.
// Reset clears control state and restores the resolution to 655.
// A stalled result holds; no new waypoint is taken until all results leave.
module waypoint_path_densifier #(
	parameter int MAX_FILL = wpd_pkg::MAX_FILL_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wpd_pkg::wpd_in_t                 in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output wpd_pkg::wpd_out_t                out_data,
	input  wire                              cfg_we,
	input  wire  [wpd_pkg::RES_W-1:0]        cfg_data
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_SQ = 4'd1, ST_SUM = 4'd2,
		ST_SQRT = 4'd3, ST_DCNT = 4'd4, ST_DX = 4'd5, ST_DY = 4'd6,
		ST_ORIG = 4'd7, ST_FILL = 4'd8, ST_FIN = 4'd9, ST_WAIT = 4'd10,
		ST_DIVW = 4'd11;

	logic [3:0]  st_q, ret_q;
	logic [16:0] res_q;
	logic signed [31:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic        fin_q, have_q, trunc_q;
	logic [23:0] pnum_q;
	logic [32:0] dx_q, dy_q;     // signed differences
	logic [63:0] sqx_q, sqy_q;
	logic [65:0] rad_q;          // radicand, shifted two bits a cycle
	logic [32:0] root_q;
	logic [34:0] rem_q;
	logic [5:0]  sq_cnt_q;
	logic [5:0]  cnt_q, k_q;
	logic signed [33:0] stx_q, sty_q;
	logic signed [39:0] px_q, py_q;
	logic        out_valid_q;
	wpd_pkg::wpd_out_t out_q;
	wpd_pkg::wpd_div_req_t dreq;
	wpd_pkg::wpd_div_rsp_t drsp;
	logic [82:0] dnum;
	logic [33:0] dden;
	logic        dstart;

	wpd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	assign dreq.start = dstart;
	assign dreq.num   = dnum;
	assign dreq.den   = dden;

	logic [16:0] res_eff;
	assign res_eff = (res_q == '0) ? 17'd1 : res_q;

	// Square root step.
	logic [34:0] rem_sh, trial;
	always_comb begin
		rem_sh = {rem_q[32:0], rad_q[65:64]};
		trial  = {root_q[32:0], 2'b01};
	end

	logic in_acc, out_acc, out_free, emit_pt;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_pt  = out_free && (st_q == ST_ORIG || st_q == ST_FILL || st_q == ST_FIN);
	assign in_stall = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -40'sh0080000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Rounded step magnitude numerator: 2*|d|*res + dist.
	logic [32:0] mag_x, mag_y;
	logic [49:0] prod_x, prod_y;
	assign mag_x  = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
	assign mag_y  = dy_q[32] ? (~dy_q + 33'd1) : dy_q;
	assign prod_x = 50'(mag_x) * 50'(res_eff);
	assign prod_y = 50'(mag_y) * 50'(res_eff);

	always_comb begin
		dstart = 1'b0;
		dnum   = '0;
		dden   = '0;
		case (st_q)
			ST_DCNT: begin
				dstart = 1'b1;
				dnum   = {50'd0, root_q};
				dden   = {17'd0, res_eff};
			end
			ST_DX: begin
				dstart = 1'b1;
				dnum   = 83'({prod_x, 1'b0}) + 83'(root_q);
				dden   = {root_q, 1'b0};
			end
			ST_DY: begin
				dstart = 1'b1;
				dnum   = 83'({prod_y, 1'b0}) + 83'(root_q);
				dden   = {root_q, 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ret_q       <= ST_IDLE;
			res_q       <= wpd_pkg::RES_RESET;
			have_q      <= 1'b0;
			pnum_q      <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) res_q <= cfg_data;
			if (emit_pt) out_valid_q <= 1'b1;
			else if (out_acc) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (in_acc) begin
					st_q <= have_q ? ST_SQ : (in_data.final_point ? ST_FIN : ST_WAIT);
				end
				ST_SQ:   st_q <= ST_SUM;
				ST_SUM:  st_q <= ST_SQRT;
				ST_SQRT: if (sq_cnt_q == 6'd0) st_q <= ST_DCNT;
				ST_DCNT: begin st_q <= ST_DIVW; ret_q <= ST_DX; end
				ST_DX:   begin st_q <= ST_DIVW; ret_q <= ST_DY; end
				ST_DY:   begin st_q <= ST_DIVW; ret_q <= ST_ORIG; end
				ST_DIVW: if (drsp.done) st_q <= ret_q;
				ST_ORIG: if (out_free) begin
					pnum_q <= pnum_q + 24'd1;
					st_q <= (cnt_q != 6'd0) ? ST_FILL : (fin_q ? ST_FIN : ST_WAIT);
				end
				ST_FILL: if (out_free) begin
					pnum_q <= pnum_q + 24'd1;
					if (k_q == cnt_q) st_q <= fin_q ? ST_FIN : ST_WAIT;
				end
				ST_FIN: if (out_free) begin
					pnum_q      <= '0;
					have_q      <= 1'b0;
					prev_x_q    <= '0;
					prev_y_q    <= '0;
					st_q        <= ST_WAIT;
				end
				ST_WAIT: if (out_free) begin
					if (!fin_q) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						have_q   <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_acc) begin
				cur_x_q <= in_data.way_x;
				cur_y_q <= in_data.way_y;
				fin_q   <= in_data.final_point;
				trunc_q <= 1'b0;
				cnt_q   <= '0;
				dx_q    <= {in_data.way_x[31], in_data.way_x} - {prev_x_q[31], prev_x_q};
				dy_q    <= {in_data.way_y[31], in_data.way_y} - {prev_y_q[31], prev_y_q};
			end
			ST_SQ: begin
				sqx_q <= {32'd0, mag_x[31:0]} * {32'd0, mag_x[31:0]};
				sqy_q <= {32'd0, mag_y[31:0]} * {32'd0, mag_y[31:0]};
			end
			ST_SUM: begin
				rad_q    <= 66'(sqx_q) + 66'(sqy_q);
				root_q   <= '0;
				rem_q    <= '0;
				sq_cnt_q <= 6'd32;
			end
			ST_SQRT: begin
				rad_q    <= {rad_q[63:0], 2'b00};
				sq_cnt_q <= sq_cnt_q - 6'd1;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			ST_DIVW: if (drsp.done) begin
				case (ret_q)
					ST_DX: begin
						if (drsp.quo > 83'(MAX_FILL + 1)) begin
							cnt_q <= 6'(MAX_FILL); trunc_q <= 1'b1;
						end else if (drsp.quo >= 83'd2) begin
							cnt_q <= 6'(drsp.quo[6:0] - 7'd1);
						end else begin
							cnt_q <= '0;
						end
					end
					ST_DY: stx_q <= dx_q[32] ? -34'(drsp.quo[32:0]) : 34'(drsp.quo[32:0]);
					default: sty_q <= dy_q[32] ? -34'(drsp.quo[32:0]) : 34'(drsp.quo[32:0]);
				endcase
			end
			ST_ORIG: if (out_free) begin
				out_q <= '{prev_x_q, prev_y_q, 1'b1, pnum_q, trunc_q,
					(cnt_q == 6'd0) && !fin_q};
				px_q  <= 40'(prev_x_q) + 40'(stx_q);
				py_q  <= 40'(prev_y_q) + 40'(sty_q);
				k_q   <= 6'd1;
			end
			ST_FILL: if (out_free) begin
				out_q <= '{sat32(px_q), sat32(py_q), 1'b0, pnum_q, trunc_q,
					(k_q == cnt_q) && !fin_q};
				px_q  <= px_q + 40'(stx_q);
				py_q  <= py_q + 40'(sty_q);
				k_q   <= k_q + 6'd1;
			end
			ST_FIN: if (out_free) begin
				out_q <= '{cur_x_q, cur_y_q, 1'b1, pnum_q, trunc_q, 1'b1};
			end
			default: ;
		endcase
	end

	// Stalled results hold, no second waypoint is taken while busy, and the fill count stays within its cap.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second waypoint taken while busy");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FILL |-> cnt_q <= 6'(MAX_FILL) && k_q <= cnt_q)
		else $error("fill count beyond cap");
endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;

	localparam int CAP         = 62;
	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE      = 400;
	localparam int MAX_SHOWN   = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	wpd_pkg::wpd_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	wpd_pkg::wpd_out_t out_data;
	logic cfg_we = 1'b0;
	logic [wpd_pkg::RES_W-1:0] cfg_data = '0;

	waypoint_path_densifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Predictor state, mirroring the block's registers.
	logic [wpd_pkg::RES_W-1:0] spacing;
	logic signed [63:0] last_x, last_y;
	logic path_open;
	logic [23:0] next_index;

	wpd_pkg::wpd_out_t pending_points[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit hold_receiver = 1'b0;
	bit stimulus_done = 1'b0;

	function automatic logic [32:0] floor_root(logic [65:0] v);
		logic [32:0] root;
		logic [67:0] rem;
		logic [67:0] trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i +: 2];
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[31:0], 1'b1};
			end else begin
				root = {root[31:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic signed [63:0] step_of(logic signed [63:0] d,
			logic [63:0] res, logic [63:0] seg_len);
		logic [127:0] m, q;
		m = (d < 0) ? -d : d;
		q = (2 * m * res + seg_len) / (2 * seg_len);
		return (d < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic push_point(logic signed [31:0] x, logic signed [31:0] y,
			logic orig, logic trunc);
		wpd_pkg::wpd_out_t p;
		p.point_x = x;
		p.point_y = y;
		p.is_original = orig;
		p.point_number = next_index;
		p.fill_truncated = trunc;
		p.run_last = 1'b0;
		pending_points = {pending_points, p};
		next_index++;
	endtask

	// Works out the points caused by one waypoint and queues them.
	task automatic densify(wpd_pkg::wpd_in_t w);
		logic signed [63:0] x, y, dx, dy, sx, sy;
		logic [63:0] ax, ay, seg_len, res, q, cnt;
		logic [65:0] sq;
		logic trunc;
		int start_count;
		start_count = pending_points.size();
		x = w.way_x;
		y = w.way_y;
		trunc = 1'b0;
		if (path_open) begin
			dx = x - last_x;
			dy = y - last_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
			seg_len = floor_root(sq);
			res = (spacing == 0) ? 64'd1 : 64'(spacing);
			q = seg_len / res;
			cnt = (q >= 2) ? q - 1 : 0;
			if (cnt > CAP) begin
				cnt = CAP;
				trunc = 1'b1;
			end
			push_point(last_x[31:0], last_y[31:0], 1'b1, trunc);
			if (cnt > 0) begin
				sx = step_of(dx, res, seg_len);
				sy = step_of(dy, res, seg_len);
				for (int k = 1; k <= cnt; k++)
					push_point(clamp32(last_x + k * sx), clamp32(last_y + k * sy),
						1'b0, trunc);
			end
		end
		if (w.final_point) begin
			push_point(w.way_x, w.way_y, 1'b1, trunc);
			last_x = 0;
			last_y = 0;
			path_open = 1'b0;
			next_index = '0;
		end else begin
			last_x = x;
			last_y = y;
			path_open = 1'b1;
		end
		if (pending_points.size() > start_count)
			pending_points[$].run_last = 1'b1;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offers one waypoint and returns at the edge of its transfer; valid stays
	// high only when the next waypoint follows with no gap.
	task automatic send(wpd_pkg::wpd_in_t w);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		densify(w);
	endtask

	// Waits until every expected point has left, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_spacing(logic [wpd_pkg::RES_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		spacing = v;
	endtask

	function automatic logic signed [31:0] rand_coord(int span);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// Directed rows: coordinates and final flag; the first row's point is typed in below.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic fin;
	} row_t;

	row_t rows[$] = '{
		'{32'sd100, 32'sd200, 1'b1},
		'{32'sd0, 32'sd0, 1'b0},
		'{32'sd3000, 32'sd4000, 1'b0},
		'{32'sd3000, 32'sd4100, 1'b0},
		'{-32'sd2000, 32'sd1000, 1'b0},
		'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0},
		'{32'sh80000000, 32'sh80000000, 1'b0},
		'{32'sh80000000, 32'sh7FFFFFFF, 1'b0},
		'{32'sh7FFFFFFF, 32'sh80000000, 1'b1},
		'{32'sd5, 32'sd5, 1'b0},
		'{32'sd5, 32'sd5, 1'b0},
		'{32'sd6, 32'sd5, 1'b1},
		'{-32'sd1, -32'sd1, 1'b1}
	};

	// Sender: directed table, configuration phases, random paths and a long hold-off.
	initial begin
		wpd_pkg::wpd_in_t w;
		logic [wpd_pkg::RES_W-1:0] sp;
		int len;
		spacing = wpd_pkg::RES_RESET;
		last_x = 0;
		last_y = 0;
		path_open = 1'b0;
		next_index = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < rows.size(); i++) begin
			w.way_x = rows[i].x;
			w.way_y = rows[i].y;
			w.final_point = rows[i].fin;
			send(w);
			// A lone final waypoint after reset comes back as itself, numbered zero.
			if (i == 0 && (pending_points.size() != 1
					|| pending_points[0].point_x != 32'sd100
					|| pending_points[0].point_y != 32'sd200
					|| pending_points[0].is_original != 1'b1
					|| pending_points[0].point_number != 24'd0
					|| pending_points[0].run_last != 1'b1)) begin
				mismatches++;
				$display("single-point path predicted wrongly");
			end
		end
		drain();
		set_spacing(17'd0);
		w = '{way_x: 32'sd0, way_y: 32'sd0, final_point: 1'b0};
		send(w);
		w = '{way_x: 32'sd30, way_y: 32'sd40, final_point: 1'b1};
		send(w);
		drain();
		set_spacing(17'h1FFFF);
		w = '{way_x: 32'sd0, way_y: 32'sd0, final_point: 1'b0};
		send(w);
		w = '{way_x: 32'sd500000, way_y: -32'sd400000, final_point: 1'b1};
		send(w);
		drain();
		// Random paths, in several spacing phases, with one long receiver hold-off.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: sp = 17'd655;
				1: sp = 17'd1;
				2: sp = 17'd65536;
				3: sp = 17'h1FFFF;
				default: sp = $urandom_range(1, 70000);
			endcase
			set_spacing(sp);
			if (ph == 2) hold_receiver = 1'b1;
			for (int i = 0; i < 50; i++) begin
				len = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0)
					w.way_x = $urandom;
				else
					w.way_x = rand_coord(int'(sp) * $urandom_range(1, 40));
				w.way_y = rand_coord(int'(sp) * $urandom_range(1, 40));
				w.final_point = (len == 0);
				send(w);
			end
			drain();
		end
		stimulus_done = 1'b1;
	end

	// Receiver: random stalls, and a long hold-off when asked.
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				hold_receiver = 1'b0;
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
			end
			g = gap_len();
			out_stall <= (g != 0);
			if (g != 0) repeat (g - 1) @(posedge clk);
		end
	end

	// Check each transfer on the result side against the oldest predicted point.
	always @(posedge clk) begin
		wpd_pkg::wpd_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected point %h", out_data);
			end else begin
				e = pending_points.pop_front();
				if (e !== out_data) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("point mismatch: expected %h actual %h", e, out_data);
				end
			end
		end
	end

	// Watchdog and end of run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || stimulus_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else if (stimulus_done) begin
			if (mismatches == 0 && pending_points.size() == 0)
				$display("TB_OK");
			else
				$display("TB_ERROR");
			$finish;
		end
	end
endmodule
`default_nettype wire

@@ files.f @@
src/wpd_pkg.sv
src/wpd_div.sv
src/waypoint_path_densifier.sv
test/testbench.sv
